/* rtl/dsfp_pkg.sv */
// ----------------------------------------------------------------------------
// Display serial frame parser package
// Character codes, frame constants and the result type shared by the parser.
// ----------------------------------------------------------------------------
package dsfp_pkg;

  localparam logic [15:0] VersionCode = 16'h0002;

  localparam logic [7:0] CharS  = 8'h53;  // 'S'
  localparam logic [7:0] CharT  = 8'h54;  // 'T'
  localparam logic [7:0] CharLt = 8'h3C;  // '<'
  localparam logic [7:0] CharGt = 8'h3E;  // '>'
  localparam logic [7:0] CharE  = 8'h45;  // 'E'

  // Trailer bytes: '>' 'E' 'T' and two further bytes.
  localparam logic [16:0] TrailerLen = 17'd5;

  localparam logic KindName   = 1'b0;
  localparam logic KindReport = 1'b1;

  typedef enum logic [5:0] {
    PhHuntS   = 6'b000001,
    PhHuntT   = 6'b000010,
    PhHuntLt  = 6'b000100,
    PhHeader  = 6'b001000,
    PhPayload = 6'b010000,
    PhTrailer = 6'b100000
  } phase_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_byte;
    logic [15:0] command_code;
    logic        is_version;
    logic [7:0]  key_value;
    logic        frame_ok;
  } res_t;

endpackage

/* rtl/dsfp_if.sv */
// ----------------------------------------------------------------------------
// Display serial frame parser channels
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface dsfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dsfp_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  name_byte;
  logic [15:0] command_code;
  logic        is_version;
  logic [7:0]  key_value;
  logic        frame_ok;

  modport source (output valid, output kind, output name_byte, output command_code,
                  output is_version, output key_value, output frame_ok, input ready);
  modport sink (input valid, input kind, input name_byte, input command_code,
                input is_version, input key_value, input frame_ok, output ready);
endinterface

/* rtl/dsfp_core.sv */
// ----------------------------------------------------------------------------
// Display serial frame parser core
// Frame state and the per-byte phase update; one byte per step strobe.
// ----------------------------------------------------------------------------
module dsfp_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  output logic          res_valid_o,
  output dsfp_pkg::res_t res_o
);

  dsfp_pkg::phase_e phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [15:0] cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  key_q, key_d;
  logic        tail_q, tail_d;
  logic        tail_next;

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    key_d       = key_q;
    tail_d      = tail_q;
    tail_next   = tail_q;
    res_valid_o = 1'b0;
    res_o.kind         = dsfp_pkg::KindName;
    res_o.name_byte    = 8'h00;
    res_o.command_code = cmd_q;
    res_o.is_version   = (cmd_q == dsfp_pkg::VersionCode);
    res_o.key_value    = 8'h00;
    res_o.frame_ok     = 1'b0;

    case (phase_q)
      dsfp_pkg::PhHuntT: begin
        if (byte_i == dsfp_pkg::CharT) phase_d = dsfp_pkg::PhHuntLt;
      end
      dsfp_pkg::PhHuntLt: begin
        if (byte_i == dsfp_pkg::CharLt) begin
          phase_d = dsfp_pkg::PhHeader;
          count_d = 16'd0;
          key_d   = 8'h00;
        end
      end
      dsfp_pkg::PhHeader: begin
        count_d = count_q + 16'd1;
        case (count_q[1:0])
          2'd0: cmd_d = {byte_i, 8'h00};
          2'd1: cmd_d = {cmd_q[15:8], byte_i};
          2'd2: len_d = {byte_i, 8'h00};
          default: begin
            len_d   = {len_q[15:8], byte_i};
            count_d = 16'd0;
            tail_d  = 1'b1;
            if ({len_q[15:8], byte_i} == 16'd0) begin
              key_d   = 8'h00;
              phase_d = dsfp_pkg::PhTrailer;
            end else begin
              phase_d = dsfp_pkg::PhPayload;
            end
          end
        endcase
      end
      dsfp_pkg::PhPayload: begin
        if ({1'b0, count_q} + 17'd1 >= {1'b0, len_q}) begin
          // The last payload byte is held back as the key value.
          key_d   = byte_i;
          count_d = 16'd0;
          tail_d  = 1'b1;
          phase_d = dsfp_pkg::PhTrailer;
        end else begin
          count_d         = count_q + 16'd1;
          res_valid_o     = 1'b1;
          res_o.name_byte = byte_i;
        end
      end
      dsfp_pkg::PhTrailer: begin
        if (count_q == 16'd0 && byte_i != dsfp_pkg::CharGt) tail_next = 1'b0;
        if (count_q == 16'd1 && byte_i != dsfp_pkg::CharE) tail_next = 1'b0;
        if (count_q == 16'd2 && byte_i != dsfp_pkg::CharT) tail_next = 1'b0;
        tail_d = tail_next;
        if ({1'b0, count_q} + 17'd1 >= dsfp_pkg::TrailerLen) begin
          res_valid_o     = 1'b1;
          res_o.kind      = dsfp_pkg::KindReport;
          res_o.key_value = key_q;
          res_o.frame_ok  = tail_next;
          phase_d         = dsfp_pkg::PhHuntS;
          count_d         = 16'd0;
        end else begin
          count_d = count_q + 16'd1;
        end
      end
      default: begin
        phase_d = (byte_i == dsfp_pkg::CharS) ? dsfp_pkg::PhHuntT : dsfp_pkg::PhHuntS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dsfp_pkg::PhHuntS;
      count_q <= 16'd0;
      cmd_q   <= 16'd0;
      len_q   <= 16'd0;
      key_q   <= 8'h00;
      tail_q  <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      key_q   <= key_d;
      tail_q  <= tail_d;
    end
  end

  // A report leaves the parser hunting for the next start byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.kind == dsfp_pkg::KindReport
    |=> phase_q == dsfp_pkg::PhHuntS && count_q == 16'd0)
    else $error("parser did not return to hunting after a report");

  // Inside the payload the position never reaches the announced length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == dsfp_pkg::PhPayload |-> count_q < len_q)
    else $error("payload position ran past the payload length");

  // Name bytes come only from the payload, never from its last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == dsfp_pkg::KindName
    |-> phase_q == dsfp_pkg::PhPayload && count_q + 16'd1 < len_q)
    else $error("name byte emitted outside the payload body");

  // The trailer position stays within the five trailer bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == dsfp_pkg::PhTrailer |-> {1'b0, count_q} < dsfp_pkg::TrailerLen)
    else $error("trailer position out of range");

endmodule

/* rtl/display_serial_frame_parser.sv */
// ----------------------------------------------------------------------------
// Display serial frame parser
// Finds 'S' .. 'T' .. '<' delimited frames in a received byte stream, streams
// payload name bytes and reports each frame end with key and tail status.
// ----------------------------------------------------------------------------
//
//   channel  dir  fields
//   -------  ---  ---------------------------------------------------------
//   rx_i     in   rx_byte
//   res_o    out  kind, name_byte, command_code, is_version, key_value,
//                 frame_ok
//
// One byte item is accepted per cycle while res_o is not stalled; a result is
// offered behind the input register and the result register.
// A byte is processed as soon as the result register is empty or being taken,
// so a stall on res_o holds at most one byte in the input register.
// Reset puts the parser in the start-byte hunt with the tail flag set.
// Bytes that produce no result still wait for a free result slot.
//
module display_serial_frame_parser (
  input  logic clk_i,
  input  logic rst_ni,
  dsfp_rx_if.sink    rx_i,
  dsfp_res_if.source res_o
);

  logic           in_v_q, in_v_d;
  logic [7:0]     in_b_q, in_b_d;
  logic           out_v_q, out_v_d;
  dsfp_pkg::res_t out_q, out_d;
  logic           step;
  logic           core_valid;
  dsfp_pkg::res_t core_res;

  assign step       = in_v_q && (!out_v_q || res_o.ready);
  assign rx_i.ready = !in_v_q || step;

  dsfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_b_q),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  always_comb begin
    in_v_d  = in_v_q;
    in_b_d  = in_b_q;
    out_v_d = out_v_q;
    out_d   = out_q;
    if (rx_i.ready) begin
      in_v_d = rx_i.valid;
      in_b_d = rx_i.rx_byte;
    end
    if (step) begin
      out_v_d = core_valid;
      out_d   = core_res;
    end else if (res_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_b_q <= in_b_d;
    out_q  <= out_d;
  end

  assign res_o.valid        = out_v_q;
  assign res_o.kind         = out_q.kind;
  assign res_o.name_byte    = out_q.name_byte;
  assign res_o.command_code = out_q.command_code;
  assign res_o.is_version   = out_q.is_version;
  assign res_o.key_value    = out_q.key_value;
  assign res_o.frame_ok     = out_q.frame_ok;

endmodule
